// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/fa2_pkg.sv -----
package fa2_pkg;

    localparam int AngleW = 16;

    localparam logic [63:0] PiQ60 = 64'h3243_F6A8_885A_308D;

    typedef struct packed {
        logic xn;
        logic yn;
        logic ax_zero;
        logic ay_zero;
        logic y_lt_x;
    } t_ctl;

endpackage

// ----- hw/rtl/fa2_prep.sv -----
`include "assert_macros.svh"

module fa2_prep #(
    parameter int InputBits = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [InputBits-1:0]     i_vec_x,
    input  logic [InputBits-1:0]     i_vec_y,
    output logic                     o_valid,
    output logic [2*InputBits+4:0]   o_num,
    output logic [2*InputBits+4:0]   o_den,
    output fa2_pkg::t_ctl            o_ctl
);
    import fa2_pkg::*;

    localparam int MW = InputBits;
    localparam int PW = 2 * MW;
    localparam int DW = 2 * MW + 5;

    logic          xn;
    logic          yn;
    logic [MW-1:0] ax;
    logic [MW-1:0] ay;
    t_ctl          n_ctl1;

    logic          r1_vld;
    logic [MW-1:0] r1_mx;
    logic [MW-1:0] r1_mn;
    t_ctl          r1_ctl;

    logic          r2_vld;
    logic [PW-1:0] r2_pxy;
    logic [PW-1:0] r2_paa;
    logic [PW-1:0] r2_pbb;
    t_ctl          r2_ctl;

    logic          r3_vld;
    logic [DW-1:0] r3_num;
    logic [DW-1:0] r3_den;
    t_ctl          r3_ctl;

    logic [DW-1:0] n_num;
    logic [DW-1:0] n_den;

    always_comb begin
        xn = i_vec_x[MW-1];
        yn = i_vec_y[MW-1];
        ax = xn ? (~i_vec_x + MW'(1)) : i_vec_x;
        ay = yn ? (~i_vec_y + MW'(1)) : i_vec_y;
        n_ctl1.xn      = xn;
        n_ctl1.yn      = yn;
        n_ctl1.ax_zero = (ax == '0);
        n_ctl1.ay_zero = (ay == '0);
        n_ctl1.y_lt_x  = (ay < ax);
    end

    always_comb begin
        n_num = (DW'(r2_pxy) << 4) + (DW'(r2_pxy) << 3) + DW'(r2_pxy);
        n_den = (DW'(r2_paa) << 4) + (DW'(r2_paa) << 3) + DW'(r2_paa)
              + (DW'(r2_pbb) << 3) - DW'(r2_pbb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_mx  <= n_ctl1.y_lt_x ? ax : ay;
        r1_mn  <= n_ctl1.y_lt_x ? ay : ax;
        r1_ctl <= n_ctl1;
        r2_pxy <= r1_mx * r1_mn;
        r2_paa <= r1_mx * r1_mx;
        r2_pbb <= r1_mn * r1_mn;
        r2_ctl <= r1_ctl;
        r3_num <= n_num;
        r3_den <= n_den;
        r3_ctl <= r2_ctl;
    end

    assign o_valid = r3_vld;
    assign o_num   = r3_num;
    assign o_den   = r3_den;
    assign o_ctl   = r3_ctl;

    `ASSERT_IMPL(a_den_nonzero, i_clk, i_rst_n, r3_vld && !r3_ctl.ax_zero, r3_den != '0)

endmodule

// ----- hw/rtl/fa2_div.sv -----
`include "assert_macros.svh"

module fa2_div #(
    parameter int InputBits = 16,
    parameter int FracBits  = 13
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [2*InputBits+4:0]   i_num,
    input  logic [2*InputBits+4:0]   i_den,
    input  fa2_pkg::t_ctl            i_ctl,
    output logic                     o_valid,
    output logic [FracBits-1:0]      o_quo,
    output fa2_pkg::t_ctl            o_ctl
);
    import fa2_pkg::*;

    localparam int DW = 2 * InputBits + 5;

    logic                r_vld [FracBits];
    logic [DW-1:0]       r_rem [FracBits];
    logic [DW-1:0]       r_den [FracBits];
    logic [FracBits-1:0] r_quo [FracBits];
    t_ctl                r_ctl [FracBits];

    for (genvar g = 0; g < FracBits; g++) begin : g_stage
        logic                vld_in;
        logic [DW-1:0]       rem_in;
        logic [DW-1:0]       den_in;
        logic [FracBits-1:0] quo_in;
        t_ctl                ctl_in;
        logic [DW:0]         rem_sh;
        logic [DW:0]         diff;
        logic                ge;
        logic [DW-1:0]       n_rem;
        logic [FracBits-1:0] n_quo;

        if (g == 0) begin : g_first
            assign vld_in = i_valid;
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
            assign ctl_in = i_ctl;
        end else begin : g_next
            assign vld_in = r_vld[g-1];
            assign rem_in = r_rem[g-1];
            assign den_in = r_den[g-1];
            assign quo_in = r_quo[g-1];
            assign ctl_in = r_ctl[g-1];
        end

        always_comb begin
            rem_sh = {rem_in, 1'b0};
            diff   = rem_sh - {1'b0, den_in};
            ge     = (rem_sh >= {1'b0, den_in});
            n_rem  = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
            n_quo  = {quo_in[FracBits-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g] <= n_rem;
            r_den[g] <= den_in;
            r_quo[g] <= n_quo;
            r_ctl[g] <= ctl_in;
        end
    end

    assign o_valid = r_vld[FracBits-1];
    assign o_quo   = r_quo[FracBits-1];
    assign o_ctl   = r_ctl[FracBits-1];

    `ASSERT_IMPL(a_rem_below_den, i_clk, i_rst_n,
                 r_vld[FracBits-1] && (r_den[FracBits-1] != '0),
                 r_rem[FracBits-1] < r_den[FracBits-1])

endmodule

// ----- hw/rtl/fa2_post.sv -----
`include "assert_macros.svh"

module fa2_post #(
    parameter int FracBits = 13
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [FracBits-1:0]          i_quo,
    input  fa2_pkg::t_ctl                i_ctl,
    output logic                         o_valid,
    output logic [fa2_pkg::AngleW-1:0]   o_angle
);
    import fa2_pkg::*;

    localparam int RW = FracBits + 4;
    localparam logic [63:0] PiFx =
        (PiQ60 + (64'd1 << (59 - FracBits))) >> (60 - FracBits);
    localparam logic [63:0] HalfPiFx =
        (PiQ60 + (64'd1 << (60 - FracBits))) >> (61 - FracBits);
    localparam logic signed [RW-1:0] PiS     = RW'(PiFx);
    localparam logic signed [RW-1:0] HalfPiS = RW'(HalfPiFx);

    logic signed [RW-1:0] q_s;
    logic signed [RW-1:0] sq;
    logic signed [RW-1:0] n_res;
    logic signed [RW-1:0] r_res;
    logic                 r_vld;

    always_comb begin
        q_s = signed'({{(RW - FracBits){1'b0}}, i_quo});
        sq  = (i_ctl.xn ^ i_ctl.yn) ? -q_s : q_s;
        if (i_ctl.ax_zero) begin
            if (i_ctl.ay_zero) begin
                n_res = '0;
            end else begin
                n_res = i_ctl.yn ? -HalfPiS : HalfPiS;
            end
        end else if (i_ctl.y_lt_x) begin
            if (!i_ctl.xn) begin
                n_res = sq;
            end else begin
                n_res = i_ctl.yn ? (sq - PiS) : (sq + PiS);
            end
        end else begin
            n_res = i_ctl.yn ? (HalfPiS - sq - PiS) : (HalfPiS - sq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid = r_vld;
    assign o_angle = AngleW'(r_res);

    `ASSERT_NEXT(a_valid_follows, i_clk, i_rst_n, i_valid, r_vld)
    `ASSERT_IMPL(a_angle_range, i_clk, i_rst_n, r_vld, (r_res <= PiS) && (r_res >= -PiS))

endmodule

// ----- hw/rtl/fast_atan2_approx.sv -----
// Fixed-point atan2 by the 0.28 rational approximation.
// A vector beat (i_vec_x, i_vec_y) is taken at each rising edge where start
// is high and busy is low. busy is held low: the pipeline never stalls, so
// one vector can be taken in every cycle.
// The angle appears on o_angle for exactly one cycle, marked by o_valid, in
// radians with ANGLE_FRACTION_BITS fraction bits, two's complement.
// The front end registers the larger and smaller magnitudes, the products
// and the scaled numerator and denominator in turn; the pipelined restoring
// divider then resolves one quotient bit per stage, and a final register
// applies sign and quadrant correction. Throughput is one beat per cycle.
// Reset clears every stage valid bit, so no result is emitted for a beat
// that was in flight at reset. The receiver cannot hold results off, and
// none is needed since results leave in the order the beats came in.
module fast_atan2_approx #(
    parameter int INPUT_BITS          = 16,
    parameter int ANGLE_FRACTION_BITS = 13
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [INPUT_BITS-1:0]        i_vec_x,
    input  logic [INPUT_BITS-1:0]        i_vec_y,
    output logic                         o_valid,
    output logic [fa2_pkg::AngleW-1:0]   o_angle
);
    import fa2_pkg::*;

    localparam int DW = 2 * INPUT_BITS + 5;

    logic                           acc;
    logic                           prep_vld;
    logic [DW-1:0]                  prep_num;
    logic [DW-1:0]                  prep_den;
    t_ctl                           prep_ctl;
    logic                           div_vld;
    logic [ANGLE_FRACTION_BITS-1:0] div_quo;
    t_ctl                           div_ctl;

    assign busy = 1'b0;
    assign acc  = start && !busy;

    fa2_prep #(
        .InputBits(INPUT_BITS)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (acc),
        .i_vec_x (i_vec_x),
        .i_vec_y (i_vec_y),
        .o_valid (prep_vld),
        .o_num   (prep_num),
        .o_den   (prep_den),
        .o_ctl   (prep_ctl)
    );

    fa2_div #(
        .InputBits(INPUT_BITS),
        .FracBits (ANGLE_FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prep_vld),
        .i_num   (prep_num),
        .i_den   (prep_den),
        .i_ctl   (prep_ctl),
        .o_valid (div_vld),
        .o_quo   (div_quo),
        .o_ctl   (div_ctl)
    );

    fa2_post #(
        .FracBits(ANGLE_FRACTION_BITS)
    ) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_vld),
        .i_quo   (div_quo),
        .i_ctl   (div_ctl),
        .o_valid (o_valid),
        .o_angle (o_angle)
    );

endmodule

// ----- tb/tb_fast_atan2_approx.sv -----
class angle_scoreboard;
    localparam int FracBits = 13;
    localparam logic [63:0] PiFx =
        (fa2_pkg::PiQ60 + (64'd1 << (59 - FracBits))) >> (60 - FracBits);
    localparam logic [63:0] HalfPiFx =
        (fa2_pkg::PiQ60 + (64'd1 << (60 - FracBits))) >> (61 - FracBits);

    logic [fa2_pkg::AngleW-1:0] expected_angles[$];
    logic [15:0] vec_x_log[$];
    logic [15:0] vec_y_log[$];
    int errors;
    int reported;

    function new();
        errors = 0;
        reported = 0;
    endfunction

    function automatic logic [fa2_pkg::AngleW-1:0] predict_angle(logic [15:0] x,
                                                                logic [15:0] y);
        int ix;
        int iy;
        longint ax;
        longint ay;
        longint num;
        longint den;
        longint quo;
        longint ang;
        ix = $signed(x);
        iy = $signed(y);
        ax = (ix < 0) ? -ix : ix;
        ay = (iy < 0) ? -iy : iy;
        num = 25 * ax * ay;
        if (ax == 0) begin
            if (ay == 0)
                ang = 0;
            else
                ang = (iy < 0) ? -longint'(HalfPiFx) : longint'(HalfPiFx);
        end else if (ay < ax) begin
            den = 25 * ax * ax + 7 * ay * ay;
            quo = (num << FracBits) / den;
            if ((ix < 0) != (iy < 0))
                quo = -quo;
            ang = quo;
            if (ix < 0)
                ang = (iy < 0) ? ang - longint'(PiFx) : ang + longint'(PiFx);
        end else begin
            den = 25 * ay * ay + 7 * ax * ax;
            quo = (num << FracBits) / den;
            if ((ix < 0) != (iy < 0))
                quo = -quo;
            ang = longint'(HalfPiFx) - quo;
            if (iy < 0)
                ang = ang - longint'(PiFx);
        end
        return ang[fa2_pkg::AngleW-1:0];
    endfunction

    function void note_vec(logic [15:0] x, logic [15:0] y);
        expected_angles.push_back(predict_angle(x, y));
        vec_x_log.push_back(x);
        vec_y_log.push_back(y);
    endfunction

    function void check_angle(logic [fa2_pkg::AngleW-1:0] angle);
        logic [fa2_pkg::AngleW-1:0] want;
        logic [15:0] x;
        logic [15:0] y;
        if (expected_angles.size() == 0) begin
            errors++;
            if (reported < 10) begin
                reported++;
                $display("angle %0d arrived with no vector outstanding", $signed(angle));
            end
            return;
        end
        want = expected_angles.pop_front();
        x = vec_x_log.pop_front();
        y = vec_y_log.pop_front();
        if (angle !== want) begin
            errors++;
            if (reported < 10) begin
                reported++;
                $display("angle mismatch for x=%0d y=%0d: expected %0d, got %0d",
                         $signed(x), $signed(y), $signed(want), $signed(angle));
            end
        end
    endfunction

    function int pending();
        return expected_angles.size();
    endfunction
endclass

module tb_fast_atan2_approx;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit = 2000;
    localparam int RandomVecs = 500;
    localparam int DrainCycles = 24;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [15:0] vec_x;
    logic [15:0] vec_y;
    logic o_valid;
    logic [fa2_pkg::AngleW-1:0] o_angle;

    angle_scoreboard sb;
    int stall_cycles;

    fast_atan2_approx dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .start   (start),
        .busy    (busy),
        .i_vec_x (vec_x),
        .i_vec_y (vec_y),
        .o_valid (o_valid),
        .o_angle (o_angle)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n) begin
            stall_cycles++;
            if (start && !busy) begin
                sb.note_vec(vec_x, vec_y);
                stall_cycles = 0;
            end
            if (o_valid) begin
                sb.check_angle(o_angle);
                stall_cycles = 0;
            end
            if (stall_cycles >= StallLimit) begin
                $display("fast_atan2_approx regression: fail");
                $finish;
            end
        end
    end

    task automatic send_vec(input logic [15:0] x, input logic [15:0] y);
        @(negedge clk);
        start <= 1'b1;
        vec_x <= x;
        vec_y <= y;
        do @(posedge clk); while (busy);
    endtask

    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge clk);
            start <= 1'b0;
            vec_x <= 16'($urandom);
            vec_y <= 16'($urandom);
        end
    endtask

    task automatic wait_all_angles();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic int pick_extreme();
        case ($urandom_range(0, 5))
            0: return -32768;
            1: return -32767;
            2: return -1;
            3: return 0;
            4: return 1;
            default: return 32767;
        endcase
    endfunction

    task automatic send_random_vec();
        int m;
        int x;
        int y;
        case ($urandom_range(0, 9))
            4: begin
                x = int'($urandom_range(0, 16)) - 8;
                y = int'($urandom_range(0, 16)) - 8;
            end
            5: begin
                x = int'($urandom_range(0, 65535)) - 32768;
                y = int'($urandom_range(0, 65535)) - 32768;
                if ($urandom_range(0, 1))
                    x = 0;
                else
                    y = 0;
            end
            6: begin
                m = $urandom_range(0, 32767);
                x = $urandom_range(0, 1) ? m : -m;
                m = m + int'($urandom_range(0, 2)) - 1;
                y = $urandom_range(0, 1) ? m : -m;
                if ($urandom_range(0, 1)) begin
                    m = x;
                    x = y;
                    y = m;
                end
            end
            7: begin
                x = pick_extreme();
                y = pick_extreme();
            end
            8: begin
                x = int'($urandom_range(0, 65535)) - 32768;
                y = int'($urandom_range(0, 6)) - 3;
                if ($urandom_range(0, 1)) begin
                    m = x;
                    x = y;
                    y = m;
                end
            end
            default: begin
                x = $urandom;
                y = $urandom;
            end
        endcase
        send_vec(16'(x), 16'(y));
    endtask

    initial begin
        logic [15:0] dir_x[$];
        logic [15:0] dir_y[$];
        sb = new();
        stall_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        vec_x = '0;
        vec_y = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Axes, diagonals, the most negative input and both sides of |y| = |x|.
        dir_x = '{16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0, -16'sd1, 16'sd1,
                  -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
                  16'sd32767, 16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd5, 16'sd3,
                  -16'sd5, -16'sd3, 16'sd32767, -16'sd32768, 16'sd1};
        dir_y = '{16'sd0, 16'sd1, 16'sd0, 16'sd32767, -16'sd32768, -16'sd1, 16'sd0,
                  16'sd0, 16'sd0, -16'sd32768, 16'sd32767, 16'sd32767,
                  -16'sd32768, 16'sd1, -16'sd1, -16'sd1, 16'sd1, 16'sd3, 16'sd5,
                  16'sd3, -16'sd5, -16'sd32767, 16'sd1, -16'sd32768};
        dir_y[2] = -16'sd1;
        dir_x[2] = 16'sd0;
        foreach (dir_x[i])
            send_vec(dir_x[i], dir_y[i]);
        wait_all_angles();

        for (int i = 0; i < RandomVecs; i++) begin
            if (i == RandomVecs / 2)
                wait_all_angles();
            if (i < RandomVecs - 100 && $urandom_range(0, 3) == 0)
                idle_sender($urandom_range(1, 8));
            send_random_vec();
        end

        wait_all_angles();
        repeat (DrainCycles) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("fast_atan2_approx regression: pass");
        else
            $display("fast_atan2_approx regression: fail");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/fa2_pkg.sv
hw/rtl/fa2_prep.sv
hw/rtl/fa2_div.sv
hw/rtl/fa2_post.sv
hw/rtl/fast_atan2_approx.sv
tb/tb_fast_atan2_approx.sv
